// ===== src/eap_pkg.sv =====
// eap_pkg: shared constants and the cordic arctangent table for the euler angle pose unit
// used by the channel interfaces, the top level and the checker; no dependencies
package eap_pkg;

  localparam int ANGLE_BITS_DEF     = 16;
  localparam int COEF_FRAC_BITS_DEF = 14;
  localparam int CORDIC_STEPS_DEF   = 16;

  localparam int XW = 34;
  localparam int ZW = 36;

  localparam logic signed [ZW-1:0] Q30_PI      = 36'sd3373259426;
  localparam logic signed [ZW-1:0] Q30_TWO_PI  = 36'sd6746518852;
  localparam logic signed [ZW-1:0] Q30_HALF_PI = 36'sd1686629713;
  localparam logic signed [XW-1:0] CORDIC_GAIN = 34'sd652032874;

  function automatic logic signed [XW-1:0] atan_step(input int unsigned i);
    logic signed [XW-1:0] r;
    r = '0;
    case (i)
      0: r = 34'sd843314856;
      1: r = 34'sd497837829;
      2: r = 34'sd263043836;
      3: r = 34'sd133525158;
      4: r = 34'sd67021686;
      5: r = 34'sd33543515;
      6: r = 34'sd16775850;
      7: r = 34'sd8388437;
      8: r = 34'sd4194282;
      9: r = 34'sd2097149;
      default: begin
        if (i < 30) r = XW'((64'd1 << (30 - i)) - 64'd1);
        else r = '0;
      end
    endcase
    return r;
  endfunction

endpackage

// ===== src/eap_in_if.sv =====
// eap_in_if: request channel carrying three euler angles and a translation
// depends on eap_pkg for the default angle width
interface eap_in_if #(
  parameter int ANGLE_BITS = eap_pkg::ANGLE_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [ANGLE_BITS-1:0] heading_angle;
  logic signed [ANGLE_BITS-1:0] pitch_angle;
  logic signed [ANGLE_BITS-1:0] roll_angle;
  logic signed [31:0]           shift_x;
  logic signed [31:0]           shift_y;
  logic signed [31:0]           shift_z;

  modport source (output valid, heading_angle, pitch_angle, roll_angle,
                  shift_x, shift_y, shift_z, input ready);
  modport sink (input valid, heading_angle, pitch_angle, roll_angle,
                shift_x, shift_y, shift_z, output ready);
endinterface

// ===== src/eap_out_if.sv =====
// eap_out_if: result channel carrying the nine rotation entries and the translation
// depends on eap_pkg for the default coefficient width
interface eap_out_if #(
  parameter int COEF_FRAC_BITS = eap_pkg::COEF_FRAC_BITS_DEF
);
  localparam int CW = COEF_FRAC_BITS + 2;
  logic                 valid;
  logic                 ready;
  logic signed [CW-1:0] rot_r0c0, rot_r0c1, rot_r0c2;
  logic signed [CW-1:0] rot_r1c0, rot_r1c1, rot_r1c2;
  logic signed [CW-1:0] rot_r2c0, rot_r2c1, rot_r2c2;
  logic signed [31:0]   trans_x, trans_y, trans_z;

  modport source (output valid, rot_r0c0, rot_r0c1, rot_r0c2, rot_r1c0, rot_r1c1,
                  rot_r1c2, rot_r2c0, rot_r2c1, rot_r2c2, trans_x, trans_y, trans_z,
                  input ready);
  modport sink (input valid, rot_r0c0, rot_r0c1, rot_r0c2, rot_r1c0, rot_r1c1,
                rot_r1c2, rot_r2c0, rot_r2c1, rot_r2c2, trans_x, trans_y, trans_z,
                output ready);
endinterface

// ===== src/euler_angles_to_pose_matrix_unit.sv =====
// euler_angles_to_pose_matrix_unit: pipelined heading/pitch/roll to [R | t] pose matrix
// depends on eap_pkg, eap_in_if and eap_out_if
//
// Each request carries heading, pitch and roll (signed Q4.(ANGLE_BITS-4) radians) and a
// translation; the result is R = Rz(heading)*Ry(pitch)*Rx(roll) in signed
// Q1.COEF_FRAC_BITS, saturated to +-1, with the translation copied through. A request is
// taken every cycle unless out_ch stalls; the pipeline has one reduction stage, one cordic
// stage per step for all three angles in parallel, a sign stage, two multiplier stages
// and the rounding/output register. The whole pipeline holds while a result waits on
// out_ch.ready, so in_ch.ready follows !out_ch.valid || out_ch.ready.
module euler_angles_to_pose_matrix_unit #(
  parameter int ANGLE_BITS     = eap_pkg::ANGLE_BITS_DEF,
  parameter int COEF_FRAC_BITS = eap_pkg::COEF_FRAC_BITS_DEF,
  parameter int CORDIC_STEPS   = eap_pkg::CORDIC_STEPS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  eap_in_if.sink     in_ch,
  eap_out_if.source  out_ch
);
  localparam int XW = eap_pkg::XW;
  localparam int ZW = eap_pkg::ZW;
  localparam int CW = COEF_FRAC_BITS + 2;
  localparam int SH = 30 - COEF_FRAC_BITS;
  localparam logic signed [63:0] RND = (SH > 0) ? (64'sd1 <<< (SH > 0 ? SH - 1 : 0)) : 64'sd0;
  localparam logic signed [63:0] ONE = 64'sd1 <<< COEF_FRAC_BITS;

  function automatic logic signed [31:0] mul30(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
    logic signed [63:0] p;
    p = 64'(a) * 64'(b) + 64'sd536870912;
    return p[61:30];
  endfunction

  function automatic logic signed [CW-1:0] to_coef(input logic signed [32:0] v);
    logic signed [63:0] t;
    t = (64'(v) + RND) >>> SH;
    if (t > ONE) t = ONE;
    if (t < -ONE) t = -ONE;
    return t[CW-1:0];
  endfunction

  logic en;

  // reduction stage
  logic signed [ANGLE_BITS-1:0] ang [0:2];
  logic signed [ZW-1:0]         zred [0:2];
  logic                         fred [0:2];

  assign ang[0] = in_ch.heading_angle;
  assign ang[1] = in_ch.pitch_angle;
  assign ang[2] = in_ch.roll_angle;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      logic signed [ZW-1:0] z;
      z = ZW'(ang[a]) <<< (34 - ANGLE_BITS);
      if (z > eap_pkg::Q30_PI) z = z - eap_pkg::Q30_TWO_PI;
      else if (z < -eap_pkg::Q30_PI) z = z + eap_pkg::Q30_TWO_PI;
      fred[a] = 1'b0;
      if (z > eap_pkg::Q30_HALF_PI) begin
        z = z - eap_pkg::Q30_PI;
        fred[a] = 1'b1;
      end else if (z < -eap_pkg::Q30_HALF_PI) begin
        z = z + eap_pkg::Q30_PI;
        fred[a] = 1'b1;
      end
      zred[a] = z;
    end
  end

  logic                 vc_r [0:CORDIC_STEPS];
  logic signed [XW-1:0] x_r  [0:CORDIC_STEPS][0:2];
  logic signed [XW-1:0] y_r  [0:CORDIC_STEPS][0:2];
  logic signed [XW-1:0] z_r  [0:CORDIC_STEPS][0:2];
  logic                 fl_r [0:CORDIC_STEPS][0:2];
  logic signed [31:0]   t_r  [0:CORDIC_STEPS][0:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r[0] <= 1'b0;
    end else if (en) begin
      vc_r[0] <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int a = 0; a < 3; a++) begin
        x_r[0][a]  <= eap_pkg::CORDIC_GAIN;
        y_r[0][a]  <= '0;
        z_r[0][a]  <= zred[a][XW-1:0];
        fl_r[0][a] <= fred[a];
      end
      t_r[0][0] <= in_ch.shift_x;
      t_r[0][1] <= in_ch.shift_y;
      t_r[0][2] <= in_ch.shift_z;
    end
  end

  // one cordic step per stage
  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
    localparam logic signed [XW-1:0] ATAN = eap_pkg::atan_step(i);
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vc_r[i+1] <= 1'b0;
      end else if (en) begin
        vc_r[i+1] <= vc_r[i];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        for (int a = 0; a < 3; a++) begin
          if (!z_r[i][a][XW-1]) begin
            x_r[i+1][a] <= x_r[i][a] - (y_r[i][a] >>> i);
            y_r[i+1][a] <= y_r[i][a] + (x_r[i][a] >>> i);
            z_r[i+1][a] <= z_r[i][a] - ATAN;
          end else begin
            x_r[i+1][a] <= x_r[i][a] + (y_r[i][a] >>> i);
            y_r[i+1][a] <= y_r[i][a] - (x_r[i][a] >>> i);
            z_r[i+1][a] <= z_r[i][a] + ATAN;
          end
          fl_r[i+1][a] <= fl_r[i][a];
          t_r[i+1][a]  <= t_r[i][a];
        end
      end
    end
  end

  // sign fix and narrowing
  logic               vf_r;
  logic signed [31:0] c_r [0:2];
  logic signed [31:0] s_r [0:2];
  logic signed [31:0] tf_r [0:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vf_r <= 1'b0;
    end else if (en) begin
      vf_r <= vc_r[CORDIC_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int a = 0; a < 3; a++) begin
        logic signed [XW-1:0] cx, sy;
        cx = fl_r[CORDIC_STEPS][a] ? -x_r[CORDIC_STEPS][a] : x_r[CORDIC_STEPS][a];
        sy = fl_r[CORDIC_STEPS][a] ? -y_r[CORDIC_STEPS][a] : y_r[CORDIC_STEPS][a];
        c_r[a]  <= cx[31:0];
        s_r[a]  <= sy[31:0];
        tf_r[a] <= t_r[CORDIC_STEPS][a];
      end
    end
  end

  // first products: 0 chsp 1 shsp 2 chcp 3 shcp 4 shcr 5 shsr 6 chcr 7 chsr 8 cpsr 9 cpcr
  logic               vm1_r;
  logic signed [31:0] m1_r [0:9];
  logic signed [31:0] sp1_r, sr1_r, cr1_r;
  logic signed [31:0] t1_r [0:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vm1_r <= 1'b0;
    end else if (en) begin
      vm1_r <= vf_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m1_r[0] <= mul30(c_r[0], s_r[1]);
      m1_r[1] <= mul30(s_r[0], s_r[1]);
      m1_r[2] <= mul30(c_r[0], c_r[1]);
      m1_r[3] <= mul30(s_r[0], c_r[1]);
      m1_r[4] <= mul30(s_r[0], c_r[2]);
      m1_r[5] <= mul30(s_r[0], s_r[2]);
      m1_r[6] <= mul30(c_r[0], c_r[2]);
      m1_r[7] <= mul30(c_r[0], s_r[2]);
      m1_r[8] <= mul30(c_r[1], s_r[2]);
      m1_r[9] <= mul30(c_r[1], c_r[2]);
      sp1_r   <= s_r[1];
      sr1_r   <= s_r[2];
      cr1_r   <= c_r[2];
      t1_r    <= tf_r;
    end
  end

  // triple products
  logic               vm2_r;
  logic signed [31:0] q_r [0:3];
  logic signed [31:0] m2_r [2:9];
  logic signed [31:0] sp2_r;
  logic signed [31:0] t2_r [0:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vm2_r <= 1'b0;
    end else if (en) begin
      vm2_r <= vm1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q_r[0] <= mul30(m1_r[0], sr1_r);
      q_r[1] <= mul30(m1_r[0], cr1_r);
      q_r[2] <= mul30(m1_r[1], sr1_r);
      q_r[3] <= mul30(m1_r[1], cr1_r);
      for (int k = 2; k < 10; k++) m2_r[k] <= m1_r[k];
      sp2_r <= sp1_r;
      t2_r  <= t1_r;
    end
  end

  // sums, rounding, saturation, output register
  logic                 vo_r;
  logic signed [CW-1:0] rot_r [0:8];
  logic signed [31:0]   to_r [0:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vo_r <= 1'b0;
    end else if (en) begin
      vo_r <= vm2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rot_r[0] <= to_coef(33'(m2_r[2]));
      rot_r[1] <= to_coef(33'(q_r[0]) - 33'(m2_r[4]));
      rot_r[2] <= to_coef(33'(q_r[1]) + 33'(m2_r[5]));
      rot_r[3] <= to_coef(33'(m2_r[3]));
      rot_r[4] <= to_coef(33'(q_r[2]) + 33'(m2_r[6]));
      rot_r[5] <= to_coef(33'(q_r[3]) - 33'(m2_r[7]));
      rot_r[6] <= to_coef(-33'(sp2_r));
      rot_r[7] <= to_coef(33'(m2_r[8]));
      rot_r[8] <= to_coef(33'(m2_r[9]));
      to_r     <= t2_r;
    end
  end

  assign en          = !vo_r || out_ch.ready;
  assign in_ch.ready = en;

  assign out_ch.valid    = vo_r;
  assign out_ch.rot_r0c0 = rot_r[0];
  assign out_ch.rot_r0c1 = rot_r[1];
  assign out_ch.rot_r0c2 = rot_r[2];
  assign out_ch.rot_r1c0 = rot_r[3];
  assign out_ch.rot_r1c1 = rot_r[4];
  assign out_ch.rot_r1c2 = rot_r[5];
  assign out_ch.rot_r2c0 = rot_r[6];
  assign out_ch.rot_r2c1 = rot_r[7];
  assign out_ch.rot_r2c2 = rot_r[8];
  assign out_ch.trans_x  = to_r[0];
  assign out_ch.trans_y  = to_r[1];
  assign out_ch.trans_z  = to_r[2];

endmodule

// ===== src/eap_checker.sv =====
// eap_checker: port-level assertions for the euler angle pose unit, bound to the top level
// depends on eap_pkg and euler_angles_to_pose_matrix_unit
module eap_checker #(
  parameter int CW = eap_pkg::COEF_FRAC_BITS_DEF + 2
) (
  input logic          clk,
  input logic          rst_n,
  input logic          in_ready,
  input logic          out_valid,
  input logic          out_ready,
  input logic [CW-1:0] out_rot_r0c0,
  input logic [31:0]   out_trans_x
);

  // stalled result stays
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_rot_r0c0) && $stable(out_trans_x))
    else $error("result changed while stalled");

  // pipeline only holds when the result is blocked
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready == (!out_valid || out_ready))
    else $error("request side ready mismatch");

  // nothing comes out right after reset
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // entry saturates within plus or minus one
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($signed(out_rot_r0c0) <= $signed(CW'(1) << (CW - 2)) &&
                   $signed(out_rot_r0c0) >= -$signed(CW'(1) << (CW - 2))))
    else $error("rotation entry out of range");

endmodule

bind euler_angles_to_pose_matrix_unit eap_checker #(.CW(COEF_FRAC_BITS + 2)) u_eap_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .out_rot_r0c0 (out_ch.rot_r0c0),
  .out_trans_x  (out_ch.trans_x)
);
